// File: hw/rtl/bfsp_pkg.sv
`default_nettype none
package bfsp_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_ENTRIES_DEF  = 1024;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int DIST_BITS_DEF    = 32;

  localparam int VCW   = 7;
  localparam int CFGIW = 2;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  localparam logic [CFGIW-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFGIW-1:0] CFG_WEIGHTED     = 2'd1;
  localparam logic [CFGIW-1:0] CFG_UNDIRECTED   = 2'd2;
  localparam logic [CFGIW-1:0] CFG_REVERSE      = 2'd3;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_WR,
    S_TWIN_RD,
    S_TWIN_WR,
    S_RESP,
    S_CLEAR,
    S_HEAD_RD,
    S_HEAD_CHK,
    S_ENT_CHK,
    S_REL,
    S_CMP,
    S_ROUND_END,
    S_OUT_RD,
    S_OUT_LD
  } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/bfsp_if.sv
`default_nettype none
interface bfsp_in_if
  import bfsp_pkg::*;
#(
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [VCW-1:0]         from_vertex;
  logic [VCW-1:0]         to_vertex;
  logic [WEIGHT_BITS-1:0] weight;
  logic [VCW-1:0]         start_vertex;

  modport source (output valid, op, from_vertex, to_vertex, weight, start_vertex, input ready);
  modport sink   (input valid, op, from_vertex, to_vertex, weight, start_vertex, output ready);
endinterface

interface bfsp_out_if
  import bfsp_pkg::*;
#(
  parameter int DIST_BITS = DIST_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [VCW-1:0]       vertex;
  logic [DIST_BITS-1:0] distance;
  logic                 reachable;
  logic                 last;

  modport source (output valid, status, vertex, distance, reachable, last, input ready);
  modport sink   (input valid, status, vertex, distance, reachable, last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bellman_ford_shortest_paths_top.sv
`default_nettype none
// Single-source shortest paths over an edge store held in on-chip memories. An add item
// keeps the input busy while it reads the head memory, writes its entry and the head and,
// when undirected edges store a twin entry, reads and writes the twin, until its result
// is loaded into the output register; a rejected item goes straight to its response. A
// run item first clears the distance memory vertex by vertex, then per round reads the
// head of each owner vertex, reads, relaxes and compares each scanned entry, skips each
// out-of-range entry and closes the round, for at most vertex_count rounds, and finally
// delivers one result per vertex. Each step of the scan is bound by the single read port
// of the edge memory followed by the read-modify-write of the distance memory.
module bellman_ford_shortest_paths_top
  import bfsp_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF,
  parameter int DIST_BITS    = DIST_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  bfsp_in_if.sink               in_if,
  bfsp_out_if.source            out_if,
  input  wire logic             cfg_we,
  input  wire logic [CFGIW-1:0] cfg_index,
  input  wire logic [VCW-1:0]   cfg_data
);

  localparam int VXW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int IDXW = $clog2(MAX_ENTRIES);
  localparam int CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int SW   = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
  localparam logic signed [SW-1:0] SUM_MAX =
    {{(SW-DIST_BITS+1){1'b0}}, {(DIST_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN =
    {{(SW-DIST_BITS+1){1'b1}}, {(DIST_BITS-1){1'b0}}};

  typedef struct packed {
    logic [VXW-1:0]         tgt;
    logic [WEIGHT_BITS-1:0] w;
    logic                   nv;
    logic [IDXW-1:0]        ni;
  } ent_t;

  logic [IDXW-1:0]      head_mem [MAX_VERTICES];
  ent_t                 ent_mem  [MAX_ENTRIES];
  logic [DIST_BITS:0]   dist_mem [MAX_VERTICES];

  logic [MAX_VERTICES-1:0] head_vld_r;
  logic [IDXW-1:0]      head_rd_r;
  logic                 head_vld_rd_r;
  ent_t                 ent_rd_r;
  logic [DIST_BITS:0]   dist_a_r, dist_b_r;

  logic                 head_re, head_we, ent_re, ent_we, dist_re, dist_we;
  logic [VXW-1:0]       head_ra, head_wa, dist_ra, dist_rb, dist_wa;
  logic [IDXW-1:0]      head_wd, ent_ra, ent_wa;
  ent_t                 ent_wd;
  logic [DIST_BITS:0]   dist_wd;

  state_t               state_r, state_nxt;
  logic [VCW-1:0]       vc_r;
  logic                 weighted_r, undir_r, rev_r;
  logic [CNTW-1:0]      cnt_r, cnt_nxt;
  logic [VXW-1:0]       u_idx_r, u_idx_nxt, v_idx_r, v_idx_nxt, src_idx_r, src_idx_nxt;
  logic [WEIGHT_BITS-1:0] w_r, w_nxt;
  logic [VCW-1:0]       idx_r, idx_nxt, owner_r, owner_nxt, round_r, round_nxt;
  logic                 changed_r, changed_nxt;
  logic [DIST_BITS-1:0] nd_r, nd_nxt;
  status_t              resp_r, resp_nxt;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [VCW-1:0]       out_vertex_r;
  logic [DIST_BITS-1:0] out_dist_r;
  logic                 out_reach_r, out_last_r;

  logic                 out_ld;
  status_t              ld_status;
  logic [VCW-1:0]       ld_vertex;
  logic [DIST_BITS-1:0] ld_dist;
  logic                 ld_reach, ld_last;

  logic [VCW-1:0]       n;
  logic                 out_free, accept;
  logic [VXW-1:0]       rel_a, rel_b;
  logic signed [SW-1:0] sum;
  logic                 from_bad, to_bad, src_bad, full;

  assign n = (32'(vc_r) > 32'(MAX_VERTICES)) ? VCW'(MAX_VERTICES) : vc_r;
  assign out_free = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign accept = in_if.valid && in_if.ready;

  assign from_bad = (in_if.from_vertex == '0) || (in_if.from_vertex > n);
  assign to_bad   = (in_if.to_vertex == '0) || (in_if.to_vertex > n);
  assign src_bad  = (in_if.start_vertex == '0) || (in_if.start_vertex > n);
  assign full     = (32'(cnt_r) + (undir_r ? 32'd2 : 32'd1)) > 32'(MAX_ENTRIES);

  assign rel_a = rev_r ? ent_rd_r.tgt : VXW'(owner_r);
  assign rel_b = rev_r ? VXW'(owner_r) : ent_rd_r.tgt;
  assign sum = SW'(signed'(dist_a_r[DIST_BITS-1:0])) + SW'(signed'(ent_rd_r.w));

  always_ff @(posedge clk) begin
    if (head_re) begin
      head_rd_r     <= head_mem[head_ra];
      head_vld_rd_r <= head_vld_r[head_ra];
    end
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (ent_re) begin
      ent_rd_r <= ent_mem[ent_ra];
    end
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    if (dist_re) begin
      dist_a_r <= dist_mem[dist_ra];
      dist_b_r <= dist_mem[dist_rb];
    end
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    u_idx_nxt   = u_idx_r;
    v_idx_nxt   = v_idx_r;
    src_idx_nxt = src_idx_r;
    w_nxt       = w_r;
    idx_nxt     = idx_r;
    owner_nxt   = owner_r;
    round_nxt   = round_r;
    changed_nxt = changed_r;
    nd_nxt      = nd_r;
    resp_nxt    = resp_r;
    head_re = 1'b0; head_ra = u_idx_r;
    head_we = 1'b0; head_wa = u_idx_r; head_wd = cnt_r[IDXW-1:0];
    ent_re  = 1'b0; ent_ra  = head_rd_r;
    ent_we  = 1'b0; ent_wa  = cnt_r[IDXW-1:0];
    ent_wd  = '{tgt: v_idx_r, w: w_r, nv: head_vld_rd_r, ni: head_rd_r};
    dist_re = 1'b0; dist_ra = rel_a; dist_rb = rel_b;
    dist_we = 1'b0; dist_wa = rel_b; dist_wd = {1'b1, nd_r};
    out_ld    = 1'b0;
    ld_status = ST_OK;
    ld_vertex = '0;
    ld_dist   = '0;
    ld_reach  = 1'b0;
    ld_last   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          u_idx_nxt   = VXW'(32'(in_if.from_vertex) - 32'd1);
          v_idx_nxt   = VXW'(32'(in_if.to_vertex) - 32'd1);
          src_idx_nxt = VXW'(32'(in_if.start_vertex) - 32'd1);
          w_nxt       = weighted_r ? in_if.weight : '0;
          idx_nxt     = '0;
          if (in_if.op == OP_ADD) begin
            if (from_bad || to_bad) begin
              resp_nxt  = ST_RANGE;
              state_nxt = S_RESP;
            end else if (full) begin
              resp_nxt  = ST_FULL;
              state_nxt = S_RESP;
            end else begin
              head_re   = 1'b1;
              head_ra   = VXW'(32'(in_if.from_vertex) - 32'd1);
              state_nxt = S_ADD_WR;
            end
          end else begin
            if (src_bad) begin
              resp_nxt  = ST_RANGE;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_CLEAR;
            end
          end
        end
      end
      S_ADD_WR: begin
        ent_we    = 1'b1;
        head_we   = 1'b1;
        cnt_nxt   = cnt_r + CNTW'(1);
        resp_nxt  = ST_OK;
        state_nxt = undir_r ? S_TWIN_RD : S_RESP;
      end
      S_TWIN_RD: begin
        head_re   = 1'b1;
        head_ra   = v_idx_r;
        state_nxt = S_TWIN_WR;
      end
      S_TWIN_WR: begin
        ent_we    = 1'b1;
        ent_wd    = '{tgt: u_idx_r, w: w_r, nv: head_vld_rd_r, ni: head_rd_r};
        head_we   = 1'b1;
        head_wa   = v_idx_r;
        cnt_nxt   = cnt_r + CNTW'(1);
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_ld    = 1'b1;
          ld_status = resp_r;
          state_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        dist_we = 1'b1;
        dist_wa = VXW'(idx_r);
        dist_wd = {(VXW'(idx_r) == src_idx_r), {DIST_BITS{1'b0}}};
        idx_nxt = idx_r + VCW'(1);
        if (idx_r + VCW'(1) == n) begin
          owner_nxt   = '0;
          round_nxt   = '0;
          changed_nxt = 1'b0;
          state_nxt   = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        head_re   = 1'b1;
        head_ra   = VXW'(owner_r);
        state_nxt = S_HEAD_CHK;
      end
      S_HEAD_CHK: begin
        if (head_vld_rd_r) begin
          ent_re    = 1'b1;
          state_nxt = S_ENT_CHK;
        end else if (owner_r + VCW'(1) == n) begin
          state_nxt = S_ROUND_END;
        end else begin
          owner_nxt = owner_r + VCW'(1);
          state_nxt = S_HEAD_RD;
        end
      end
      S_ENT_CHK, S_CMP: begin
        if (state_r == S_CMP && dist_a_r[DIST_BITS] &&
            !(dist_b_r[DIST_BITS] && $signed(dist_b_r[DIST_BITS-1:0]) <= $signed(nd_r))) begin
          dist_we     = 1'b1;
          changed_nxt = 1'b1;
        end
        if (state_r == S_ENT_CHK && 32'(ent_rd_r.tgt) < 32'(n)) begin
          dist_re   = 1'b1;
          state_nxt = S_REL;
        end else if (ent_rd_r.nv) begin
          ent_re    = 1'b1;
          ent_ra    = ent_rd_r.ni;
          state_nxt = S_ENT_CHK;
        end else if (owner_r + VCW'(1) == n) begin
          state_nxt = S_ROUND_END;
        end else begin
          owner_nxt = owner_r + VCW'(1);
          state_nxt = S_HEAD_RD;
        end
      end
      S_REL: begin
        if (sum > SUM_MAX) begin
          nd_nxt = SUM_MAX[DIST_BITS-1:0];
        end else if (sum < SUM_MIN) begin
          nd_nxt = SUM_MIN[DIST_BITS-1:0];
        end else begin
          nd_nxt = sum[DIST_BITS-1:0];
        end
        state_nxt = S_CMP;
      end
      S_ROUND_END: begin
        if (!changed_r || round_r + VCW'(1) == n) begin
          idx_nxt   = '0;
          state_nxt = S_OUT_RD;
        end else begin
          round_nxt   = round_r + VCW'(1);
          owner_nxt   = '0;
          changed_nxt = 1'b0;
          state_nxt   = S_HEAD_RD;
        end
      end
      S_OUT_RD: begin
        dist_re   = 1'b1;
        dist_ra   = VXW'(idx_r);
        state_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        if (out_free) begin
          out_ld    = 1'b1;
          ld_vertex = idx_r + VCW'(1);
          ld_reach  = dist_a_r[DIST_BITS];
          ld_dist   = dist_a_r[DIST_BITS] ? dist_a_r[DIST_BITS-1:0] : '0;
          ld_last   = (idx_r + VCW'(1) == n);
          idx_nxt   = idx_r + VCW'(1);
          state_nxt = ld_last ? S_IDLE : S_OUT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vc_r        <= VCW'(64);
      weighted_r  <= 1'b1;
      undir_r     <= 1'b0;
      rev_r       <= 1'b0;
      cnt_r       <= '0;
      head_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (head_we) begin
        head_vld_r[head_wa] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_VERTEX_COUNT: vc_r       <= cfg_data;
          CFG_WEIGHTED:     weighted_r <= cfg_data[0];
          CFG_UNDIRECTED:   undir_r    <= cfg_data[0];
          CFG_REVERSE:      rev_r      <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    u_idx_r   <= u_idx_nxt;
    v_idx_r   <= v_idx_nxt;
    src_idx_r <= src_idx_nxt;
    w_r       <= w_nxt;
    idx_r     <= idx_nxt;
    owner_r   <= owner_nxt;
    round_r   <= round_nxt;
    changed_r <= changed_nxt;
    nd_r      <= nd_nxt;
    resp_r    <= resp_nxt;
    if (out_ld) begin
      out_status_r <= ld_status;
      out_vertex_r <= ld_vertex;
      out_dist_r   <= ld_dist;
      out_reach_r  <= ld_reach;
      out_last_r   <= ld_last;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.status    = 2'(out_status_r);
  assign out_if.vertex    = out_vertex_r;
  assign out_if.distance  = out_dist_r;
  assign out_if.reachable = out_reach_r;
  assign out_if.last      = out_last_r;

endmodule
`default_nettype wire
